@@ design/ledsa_pkg.sv @@
// Shared types, constants and tables for the LED strip animation engine.
// No dependencies; imported by ledsa_fade_unit and led_strip_animation_engine_unit.
package ledsa_pkg;

  localparam int LED_COUNT = 16;
  localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int HALF      = LED_COUNT / 2;
  localparam int PIX_W     = 6;
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 3 * CH_W;
  localparam int LEVEL_W   = 5;
  localparam int FSTEP_W   = 6;
  localparam int BSTEP_W   = 5;
  localparam int PROD_W    = 13;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // fade triangle: 0 .. 30 .. 0 over 61 ticks
  localparam logic [FSTEP_W-1:0] FADE_WRAP = FSTEP_W'(60);
  localparam logic [FSTEP_W-1:0] FADE_PEAK = FSTEP_W'(30);
  // divide by 30: multiply by floor(2^17/30), then one correction step
  localparam logic [PROD_W-1:0]  DIV_30      = PROD_W'(30);
  localparam logic [PROD_W-1:0]  RECIP_30    = PROD_W'(4369);
  localparam int                 RECIP_SHIFT = 17;

  localparam logic [BSTEP_W-1:0] BLINK_FIRST  = BSTEP_W'(10);
  localparam logic [BSTEP_W-1:0] BLINK_SECOND = BSTEP_W'(20);

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_SOLID   = 3'd1,
    MODE_FADE    = 3'd2,
    MODE_BLINK   = 3'd3,
    MODE_RAINBOW = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_EMIT
  } eng_state_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_REC,
    FS_COR
  } fade_state_t;

  typedef enum logic [1:0] {
    BP_HOLD,
    BP_FIRST,
    BP_SECOND
  } blink_phase_t;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] level;
  } fade_req_t;

  typedef logic [CH_W-1:0] base_tab_t [LED_COUNT];

  function automatic base_tab_t make_wheel_base();
    base_tab_t t;
    for (int k = 0; k < LED_COUNT; k++) begin
      t[k] = CH_W'((k * 256) / LED_COUNT);
    end
    return t;
  endfunction

  // wheel start position of each LED
  localparam base_tab_t WHEEL_BASE = make_wheel_base();

  function automatic logic [COLOR_W-1:0] wheel_color(input logic [CH_W-1:0] pos);
    logic [CH_W-1:0] p;
    logic [CH_W-1:0] up;
    logic [CH_W-1:0] dn;
    p = pos;
    if (pos >= CH_W'(170)) begin
      p = pos - CH_W'(170);
    end else if (pos >= CH_W'(85)) begin
      p = pos - CH_W'(85);
    end
    up = CH_W'({p, 1'b0}) + p;
    dn = CH_W'(255) - up;
    if (pos < CH_W'(85)) begin
      wheel_color = {up, dn, CH_W'(0)};
    end else if (pos < CH_W'(170)) begin
      wheel_color = {dn, CH_W'(0), up};
    end else begin
      wheel_color = {CH_W'(0), up, dn};
    end
  endfunction

endpackage

@@ design/ledsa_fade_unit.sv @@
// Fade scaler: each channel times level / 30, truncating, one shared multiplier.
// Depends on ledsa_pkg.
module ledsa_fade_unit import ledsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  fade_req_t          req,
  input  logic [COLOR_W-1:0] color,
  output logic               done,
  output logic [COLOR_W-1:0] scaled
);

  fade_state_t          state;
  fade_state_t          state_next;
  logic [1:0]           ch;
  logic [LEVEL_W-1:0]   level;
  logic [PROD_W-1:0]    prod;
  logic [CH_W-1:0]      q;
  logic [CH_W-1:0]      chan;
  logic [PROD_W-1:0]    mul_a;
  logic [PROD_W-1:0]    mul_b;
  logic [2*PROD_W-1:0]  mul_p;
  logic [PROD_W-1:0]    q30;
  logic [PROD_W-1:0]    rem;
  logic [CH_W-1:0]      q_fix;

  always_comb begin
    case (ch)
      2'd0:    chan = color[3*CH_W-1:2*CH_W];
      2'd1:    chan = color[2*CH_W-1:CH_W];
      default: chan = color[CH_W-1:0];
    endcase
  end

  // the one multiplier: channel x level, then product x reciprocal
  always_comb begin
    if (state == FS_REC) begin
      mul_a = prod;
      mul_b = RECIP_30;
    end else begin
      mul_a = PROD_W'(chan);
      mul_b = PROD_W'(level);
    end
    mul_p = mul_a * mul_b;
  end

  // estimate is never high; at most one short
  assign q30   = PROD_W'({q, 5'b0}) - PROD_W'({q, 1'b0});
  assign rem   = prod - q30;
  assign q_fix = (rem >= DIV_30) ? q + CH_W'(1) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: if (req.start) state_next = FS_MUL;
      FS_MUL:  state_next = FS_REC;
      FS_REC:  state_next = FS_COR;
      FS_COR: begin
        if (ch == 2'd2) begin
          state_next = FS_IDLE;
        end else begin
          state_next = FS_MUL;
        end
      end
      default: state_next = FS_IDLE;
    endcase
  end

  // done follows the last channel write, so all of scaled is settled
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == FS_COR) && (ch == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= 2'd0;
    end else if (state == FS_IDLE && req.start) begin
      ch <= 2'd0;
    end else if (state == FS_COR) begin
      ch <= ch + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FS_IDLE && req.start) begin
      level <= req.level;
    end
    if (state == FS_MUL) begin
      prod <= mul_p[PROD_W-1:0];
    end
    if (state == FS_REC) begin
      q <= mul_p[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    end
    if (state == FS_COR) begin
      case (ch)
        2'd0:    scaled[3*CH_W-1:2*CH_W] <= q_fix;
        2'd1:    scaled[2*CH_W-1:CH_W]   <= q_fix;
        default: scaled[CH_W-1:0]        <= q_fix;
      endcase
    end
  end

endmodule

@@ design/led_strip_animation_engine_unit.sv @@
// LED strip animation engine top level: command intake, frame sequencer,
// frame store and pixel output register. Depends on ledsa_pkg, ledsa_fade_unit.
//
//  channel | valid / stall        | payload
//  --------+----------------------+-------------------------------------------------
//  cmd     | cmd_valid/cmd_stall  | command, mode, red_in, green_in, blue_in
//  pix     | pix_valid/pix_stall  | pixel_index, red_out, green_out, blue_out, last_pixel
//
// A set transaction or a tick that renders nothing does not raise cmd_stall.
// A rendering tick emits LED_COUNT pixels, one per cycle while pix is not stalled;
// fade first scales the colour through the shared multiplier (3 channels x 3 steps),
// then hands over the scaled color.
// cmd_stall is high from an accepted rendering tick until its last pixel is loaded.
// Synchronous reset clears the mode, colour, counters and the frame store.
// The pixel output register holds its transaction while pix_stall is high.
module led_strip_animation_engine_unit import ledsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  logic             command,
  input  logic [2:0]       mode,
  input  logic [CH_W-1:0]  red_in,
  input  logic [CH_W-1:0]  green_in,
  input  logic [CH_W-1:0]  blue_in,
  output logic             pix_valid,
  input  logic             pix_stall,
  output logic [PIX_W-1:0] pixel_index,
  output logic [CH_W-1:0]  red_out,
  output logic [CH_W-1:0]  green_out,
  output logic [CH_W-1:0]  blue_out,
  output logic             last_pixel
);

  eng_state_t            state;
  eng_state_t            state_next;

  // animation state
  logic [2:0]            current_mode;
  logic [COLOR_W-1:0]    current_color;
  logic                  pending_solid;
  logic [FSTEP_W-1:0]    fade_step;
  logic [BSTEP_W-1:0]    blink_step;
  logic [CH_W-1:0]       wheel_offset;
  logic [COLOR_W-1:0]    frame_store [LED_COUNT];

  // per-frame working registers
  logic [COLOR_W-1:0]    fill_color;
  blink_phase_t          blink_phase;
  logic [IDX_W-1:0]      pix;

  logic                  cmd_take;
  logic                  is_tick;
  logic                  go_solid;
  logic                  go_fade;
  logic                  go_emit;
  logic                  out_free;
  logic                  pixel_step;
  logic                  pix_last;
  logic [FSTEP_W-1:0]    fade_cur;
  logic [FSTEP_W-1:0]    fade_tri;
  logic [COLOR_W-1:0]    pix_color;
  logic [IDX_W:0]        pix_wide;
  fade_req_t             fade_req;
  logic                  fade_done;
  logic [COLOR_W-1:0]    fade_scaled;

  assign cmd_stall = (state != ST_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign is_tick   = cmd_take && (command == CMD_TICK);

  // which tick kinds start a frame
  assign go_solid = is_tick && (current_mode == MODE_SOLID) && pending_solid;
  assign go_fade  = is_tick && (current_mode == MODE_FADE);
  assign go_emit  = is_tick && ((current_mode == MODE_BLINK) ||
                                (current_mode == MODE_RAINBOW) || go_solid);

  // fade triangle level from the step counter
  assign fade_cur = (fade_step > FADE_WRAP) ? FSTEP_W'(0) : fade_step;
  assign fade_tri = (fade_cur > FADE_PEAK) ? (FADE_WRAP - fade_cur) : fade_cur;

  assign fade_req.start = go_fade;
  assign fade_req.level = fade_tri[LEVEL_W-1:0];

  ledsa_fade_unit u_fade (
    .clk    (clk),
    .rst    (rst),
    .req    (fade_req),
    .color  (current_color),
    .done   (fade_done),
    .scaled (fade_scaled)
  );

  // output slot free when empty or being taken this edge
  assign out_free   = !pix_valid || !pix_stall;
  assign pixel_step = (state == ST_EMIT) && out_free;
  assign pix_last   = (pix == IDX_W'(LED_COUNT - 1));
  assign pix_wide   = {1'b0, pix};

  // color of the current pixel; also written back to the frame store
  always_comb begin
    case (current_mode)
      MODE_BLINK: begin
        case (blink_phase)
          BP_FIRST:  pix_color = (pix_wide < (IDX_W+1)'(HALF)) ? current_color : '0;
          BP_SECOND: pix_color = (pix_wide >= (IDX_W+1)'(HALF) &&
                                  pix_wide < (IDX_W+1)'(2 * HALF)) ? current_color : '0;
          default:   pix_color = frame_store[pix];
        endcase
      end
      MODE_RAINBOW: pix_color = wheel_color(WHEEL_BASE[pix] + wheel_offset);
      default:      pix_color = fill_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go_fade) begin
          state_next = ST_SCALE;
        end else if (go_emit) begin
          state_next = ST_EMIT;
        end
      end
      ST_SCALE: if (fade_done) state_next = ST_EMIT;
      ST_EMIT:  if (pixel_step && pix_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // animation state and frame store
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode  <= MODE_OFF;
      current_color <= '0;
      pending_solid <= 1'b0;
      fade_step     <= '0;
      blink_step    <= '0;
      wheel_offset  <= '0;
      blink_phase   <= BP_HOLD;
      for (int k = 0; k < LED_COUNT; k++) begin
        frame_store[k] <= '0;
      end
    end else begin
      if (cmd_take && command == CMD_SET) begin
        current_mode  <= mode;
        current_color <= {red_in, green_in, blue_in};
        pending_solid <= 1'b1;
      end
      if (go_solid) begin
        pending_solid <= 1'b0;
      end
      if (go_fade) begin
        fade_step <= fade_cur + FSTEP_W'(1);
      end
      if (is_tick && current_mode == MODE_BLINK) begin
        if (blink_step == BLINK_FIRST) begin
          blink_phase <= BP_FIRST;
          blink_step  <= blink_step + BSTEP_W'(1);
        end else if (blink_step == BLINK_SECOND) begin
          blink_phase <= BP_SECOND;
          blink_step  <= BSTEP_W'(1);
        end else begin
          blink_phase <= BP_HOLD;
          blink_step  <= blink_step + BSTEP_W'(1);
        end
      end
      if (pixel_step) begin
        frame_store[pix] <= pix_color;
        if (pix_last && current_mode == MODE_RAINBOW) begin
          wheel_offset <= wheel_offset + CH_W'(1);
        end
      end
    end
  end

  // pixel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (pixel_step) begin
      pix <= pix_last ? '0 : pix + IDX_W'(1);
    end
  end

  // frame fill color for solid and fade
  always_ff @(posedge clk) begin
    if (go_solid) begin
      fill_color <= current_color;
    end else if (state == ST_SCALE && fade_done) begin
      fill_color <= fade_scaled;
    end
  end

  // pixel output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pixel_step) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_step) begin
      pixel_index <= PIX_W'(pix);
      red_out     <= pix_color[3*CH_W-1:2*CH_W];
      green_out   <= pix_color[2*CH_W-1:CH_W];
      blue_out    <= pix_color[CH_W-1:0];
      last_pixel  <= pix_last;
    end
  end

endmodule
